[hw/rtl/bin2_pkg.sv]
`default_nettype none

package bin2_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int PAIR_BITS    = SAMPLE_BITS + 1;
  localparam int SUM_BITS     = SAMPLE_BITS + 2;
  localparam int CFG_BITS     = 11;
  localparam int LINE_DEPTH   = (MAX_WIDTH + 1) / 2;
  localparam int IDX_BITS     = $clog2(LINE_DEPTH);
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
  localparam int OP_DEPTH     = 4;
  localparam int OP_PTR_BITS  = $clog2(OP_DEPTH);
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,  // even row, not last: store pair sum in line
    OP_DIRECT = 2'd1,  // even last row: pair sum is the result
    OP_MERGE  = 2'd2   // odd row: line entry plus pair sum
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [PAIR_BITS-1:0]  pair;
    logic [IDX_BITS-1:0]   idx;
    logic                  row_end;
    logic                  frame_end;
  } op_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] block_sum;
    logic                row_end;
    logic                frame_end;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/bin2_ram.sv]
`default_nettype none

module bin2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bin2_front.sv]
`default_nettype none

module bin2_front
  import bin2_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  input  wire logic                          accept,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               op_push,
  output op_t                                op
);

  logic [CFG_BITS-1:0]          width_r;
  logic [CFG_BITS-1:0]          height_r;
  logic [COL_BITS-1:0]          col_r, col_nxt;
  logic [ROW_BITS-1:0]          row_r, row_nxt;
  logic signed [SAMPLE_BITS-1:0] held_r;
  logic [CFG_BITS-1:0]          eff_w, eff_h;
  logic                         last_col, last_row;
  logic signed [PAIR_BITS-1:0]  pair;

  always_comb begin
    if (width_r == '0) begin
      eff_w = CFG_BITS'(1);
    end else if (width_r > CFG_BITS'(MAX_WIDTH)) begin
      eff_w = CFG_BITS'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = CFG_BITS'(1);
    end else if (height_r > CFG_BITS'(HEIGHT_LIMIT)) begin
      eff_h = CFG_BITS'(HEIGHT_LIMIT);
    end else begin
      eff_h = height_r;
    end
  end

  // a counter past the last column or row after a size change ends there
  assign last_col = (CFG_BITS'(col_r) + CFG_BITS'(1)) >= eff_w;
  assign last_row = (CFG_BITS'(row_r) + CFG_BITS'(1)) >= eff_h;

  assign pair = col_r[0] ? (PAIR_BITS'(held_r) + PAIR_BITS'(sample)) : PAIR_BITS'(sample);

  always_comb begin
    op.pair      = pair;
    op.idx       = col_r[COL_BITS-1:1];
    op.row_end   = last_col;
    op.frame_end = last_col && last_row;
    if (row_r[0]) begin
      op.kind = OP_MERGE;
    end else if (last_row) begin
      op.kind = OP_DIRECT;
    end else begin
      op.kind = OP_WRITE;
    end
  end

  assign op_push = accept && (col_r[0] || last_col);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_BITS'(MAX_WIDTH);
      height_r <= CFG_BITS'(HEIGHT_LIMIT);
      col_r    <= '0;
      row_r    <= '0;
      held_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_FRAME_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_FRAME_HEIGHT) begin
        height_r <= cfg_data;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept && !col_r[0]) begin
        held_r <= sample;
      end
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    op_push && op.frame_end |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap after frame end");

endmodule

`default_nettype wire

[hw/rtl/bin2_queue.sv]
`default_nettype none

module bin2_queue
  import bin2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output op_t       head
);

  op_t                    slot_r [OP_DEPTH];
  logic [OP_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [OP_PTR_BITS:0]   count_r;
  logic                   do_push, do_pop;

  assign full    = count_r == (OP_PTR_BITS+1)'(OP_DEPTH);
  assign valid   = count_r != '0;
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + OP_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + OP_PTR_BITS'(1);
      end
      count_r <= count_r + (OP_PTR_BITS+1)'(do_push) - (OP_PTR_BITS+1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (OP_PTR_BITS+1)'(OP_DEPTH))
    else $error("op queue count overflow");

endmodule

`default_nettype wire

[hw/rtl/bin2_back.sv]
`default_nettype none

module bin2_back
  import bin2_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     op_valid,
  input  wire op_t      op,
  output logic          op_pop,
  output logic          res_valid,
  output result_t       res,
  input  wire logic     res_pop
);

  op_t                     s2_op_r;
  logic                    s2_valid_r;
  logic [PAIR_BITS-1:0]    line_rdata;
  logic                    room;
  logic                    is_write;
  logic signed [SUM_BITS-1:0] line_ext, pair_ext, sum;
  result_t                 s2_res;

  result_t                 out_r [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] out_wr_r, out_rd_r;
  logic [OUT_PTR_BITS:0]   out_cnt_r;
  logic                    out_push, out_pop;

  // reserve a result slot for the op in flight before issuing another
  assign room     = (out_cnt_r + (OUT_PTR_BITS+1)'(s2_valid_r)) <
                    (OUT_PTR_BITS+1)'(OUT_DEPTH);
  assign op_pop   = op_valid && room;
  assign is_write = op.kind == OP_WRITE;

  bin2_ram #(
    .WIDTH (PAIR_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (op_pop && is_write),
    .waddr (op.idx),
    .wdata (op.pair),
    .re    (op_pop && op.kind == OP_MERGE),
    .raddr (op.idx),
    .rdata (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (op_pop) begin
      s2_op_r <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= op_pop && !is_write;
    end
  end

  assign line_ext = SUM_BITS'($signed(line_rdata));
  assign pair_ext = SUM_BITS'($signed(s2_op_r.pair));
  assign sum      = (s2_op_r.kind == OP_MERGE) ? (line_ext + pair_ext) : pair_ext;

  always_comb begin
    s2_res.block_sum = sum;
    s2_res.row_end   = s2_op_r.row_end;
    s2_res.frame_end = s2_op_r.frame_end;
  end

  // result queue
  assign out_push  = s2_valid_r;
  assign res_valid = out_cnt_r != '0;
  assign out_pop   = res_pop && res_valid;
  assign res       = out_r[out_rd_r];

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_r[out_wr_r] <= s2_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_r  <= '0;
      out_rd_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      if (out_push) begin
        out_wr_r <= out_wr_r + OUT_PTR_BITS'(1);
      end
      if (out_pop) begin
        out_rd_r <= out_rd_r + OUT_PTR_BITS'(1);
      end
      out_cnt_r <= out_cnt_r + (OUT_PTR_BITS+1)'(out_push) - (OUT_PTR_BITS+1)'(out_pop);
    end
  end

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= (OUT_PTR_BITS+1)'(OUT_DEPTH))
    else $error("result queue overflow");

  a_slot_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> out_cnt_r < (OUT_PTR_BITS+1)'(OUT_DEPTH))
    else $error("op issued without a result slot");

  a_no_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop && is_write |=> !s2_valid_r)
    else $error("line write produced a result");

endmodule

`default_nettype wire

[hw/rtl/binning_2x2_sum_top.sv]
`default_nettype none

// 2x2 binning by summation over a raster stream of signed samples. Push one
// sample per cycle; each result is the sum of one 2x2 block, with neighbours
// beyond an odd width or height counted as zero, so a frame of W x H gives
// ceil(W/2) x ceil(H/2) results, row_end on the last of each output row and
// frame_end on the last of the frame. The block sustains one sample per
// clock while results are taken: the front counts columns and rows and
// forms pair sums as samples arrive, a four-entry op queue feeds the back,
// which reads or writes the half-width line store (at most one access per
// op) and adds. A result passes the op queue, the s2 register and the
// result queue, and four results can wait while the output is stalled.
// The line store needs no clearing pass; there is no start-up delay after
// reset. Write frame_width and frame_height only between frames while idle.

module binning_2x2_sum_top
  import bin2_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  // sample input
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  // result output
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SUM_BITS-1:0]         out_block_sum,
  output logic                               out_row_end,
  output logic                               out_frame_end
);

  logic    accept;
  logic    op_push;
  op_t     op_in;
  logic    q_valid;
  op_t     q_head;
  logic    q_pop;
  logic    res_valid;
  result_t res;

  // a sample transfer happens whenever push is high and the op queue has room
  assign accept = push && !full;

  bin2_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    (in_sample),
    .op_push   (op_push),
    .op        (op_in)
  );

  // decouple the classifier from the line store and output stall
  bin2_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (op_in),
    .full    (full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  bin2_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op        (q_head),
    .op_pop    (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty         = !res_valid;
  assign out_block_sum = $signed(res.block_sum);
  assign out_row_end   = res.row_end;
  assign out_frame_end = res.frame_end;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    op_push |-> !full)
    else $error("op pushed into a full queue");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bin2_pkg::*;

  // Wait after the last expected result before touching the size registers:
  // a sample that only writes the line store can still sit in the op queue.
  localparam int unsigned SETTLE_CYCLES  = 12;
  // Long receiver hold-off, long enough to fill the op and result queues.
  localparam int unsigned HOLD_CYCLES    = 200;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_SAMPLES = 550;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          cfg_we        = 1'b0;
  logic                          cfg_index     = REG_FRAME_WIDTH;
  logic [CFG_BITS-1:0]           cfg_data      = '0;
  logic                          push          = 1'b0;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] in_sample     = '0;
  logic                          empty;
  logic                          pop           = 1'b0;
  logic signed [SUM_BITS-1:0]    out_block_sum;
  logic                          out_row_end;
  logic                          out_frame_end;

  // Binning predictor: size registers, held left sample, pair-sum line and
  // the raster position of the next sample.
  logic [CFG_BITS-1:0]           width_reg  = CFG_BITS'(MAX_WIDTH);
  logic [CFG_BITS-1:0]           height_reg = CFG_BITS'(HEIGHT_LIMIT);
  logic signed [SAMPLE_BITS-1:0] left_sample = '0;
  logic signed [PAIR_BITS-1:0]   pair_sums [LINE_DEPTH];
  int unsigned                   col_pos = 0;
  int unsigned                   row_pos = 0;

  // Block sums still owed by the block, oldest first.
  result_t expected_blocks [$];

  int unsigned samples_sent   = 0;
  int unsigned blocks_checked = 0;
  int unsigned mismatch_count = 0;

  // Idle ranges: the sender gap lives in the stimulus process, the receiver
  // range is read by the receiver and therefore driven at the clock edge.
  int unsigned push_gap_max  = 9;
  int unsigned pop_gap_max   = 9;
  int unsigned hold_requests = 0;

  int unsigned pop_delay;
  int unsigned pop_draw;
  int unsigned hold_count;
  int unsigned hold_seen;
  int unsigned quiet_cycles = 0;

  binning_2x2_sum_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .in_sample    (in_sample),
    .empty        (empty),
    .pop          (pop),
    .out_block_sum(out_block_sum),
    .out_row_end  (out_row_end),
    .out_frame_end(out_frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predictor by one accepted sample and queue the block sum it
  // completes, if any.
  task automatic predict_block(input logic signed [SAMPLE_BITS-1:0] value);
    int unsigned                 cols;
    int unsigned                 rows;
    int unsigned                 idx;
    logic                        last_col;
    logic                        last_row;
    logic                        have_pair;
    logic signed [PAIR_BITS-1:0] pair;
    logic signed [SUM_BITS-1:0]  sum;
    result_t                     block;
    // zero sizes act as one, oversize registers clamp to the maximum
    cols = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    rows = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    // a position at or past the last column or row stands on it
    last_col  = (col_pos + 1 >= cols);
    last_row  = (row_pos + 1 >= rows);
    have_pair = 1'b1;
    if (col_pos[0] == 1'b0) begin
      left_sample = value;
      pair        = value;      // odd width: zero right neighbour
      have_pair   = last_col;
    end else begin
      pair = left_sample + value;
    end
    if (have_pair) begin
      idx = col_pos / 2;
      if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
      if (row_pos[0] == 1'b0 && !last_row) begin
        pair_sums[idx] = pair;
      end else begin
        // last even row of an odd height pairs with a zero row below
        sum = (row_pos[0] == 1'b0) ? SUM_BITS'(pair) : pair_sums[idx] + pair;
        block.block_sum = sum;
        block.row_end   = last_col;
        block.frame_end = last_col && last_row;
        expected_blocks.push_back(block);
      end
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic int unsigned random_extent(input int unsigned common_max,
                                                input int unsigned rare_max);
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, rare_max);
    return $urandom_range(1, common_max);
  endfunction

  // Offer one sample after a random gap and hold it until the transfer.
  // Push stays high on return so a back-to-back sample keeps the stream full.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    int unsigned gap;
    gap = $urandom_range(0, push_gap_max);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_block(value);
    samples_sent++;
  endtask

  // Send random samples until the raster position wraps to the frame start.
  task automatic run_frame();
    do send_sample(random_sample());
    while (col_pos != 0 || row_pos != 0);
  endtask

  // Drop push and let the block drain so that it is idle.
  task automatic settle();
    push <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input int unsigned frame_cols, input int unsigned frame_rows);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= CFG_BITS'(frame_cols);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= CFG_BITS'(frame_rows);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    width_reg  = CFG_BITS'(frame_cols);
    height_reg = CFG_BITS'(frame_rows);
  endtask

  // Compare the result at the output with the oldest expected block sum.
  task automatic check_block_result();
    result_t want;
    if (expected_blocks.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("result %0d not expected: sum %0d row_end %0b frame_end %0b",
                 blocks_checked, out_block_sum, out_row_end, out_frame_end);
    end else begin
      want = expected_blocks.pop_front();
      if (want.block_sum !== out_block_sum || want.row_end !== out_row_end ||
          want.frame_end !== out_frame_end) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result %0d mismatch: expected sum %0d row_end %0b frame_end %0b, %s",
                   blocks_checked, $signed(want.block_sum), want.row_end, want.frame_end,
                   $sformatf("got sum %0d row_end %0b frame_end %0b",
                             out_block_sum, out_row_end, out_frame_end));
      end
    end
    blocks_checked++;
  endtask

  // Receiver: check every transfer, then idle a random number of cycles.
  // A new hold request drops pop for a long stretch so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop        <= 1'b0;
      pop_delay  <= 0;
      hold_count <= 0;
      hold_seen  <= 0;
    end else begin
      if (pop && !empty) check_block_result();
      if (hold_seen != hold_requests) begin
        hold_seen  <= hold_requests;
        hold_count <= HOLD_CYCLES;
        pop        <= 1'b0;
      end else if (hold_count != 0) begin
        hold_count <= hold_count - 1;
      end else if (pop && !empty) begin
        pop_draw = $urandom_range(0, pop_gap_max);
        pop_delay <= pop_draw;
        pop       <= (pop_draw == 0);
      end else if (!pop) begin
        if (pop_delay != 0) pop_delay <= pop_delay - 1;
        else pop <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[binning_2x2_sum_top] ERROR");
        $finish;
      end
    end
  end

  // Full-scale sums at both ends, then an odd-by-odd frame so the last
  // column and the last row pair with zeros.
  task automatic test_extreme_samples();
    logic signed [SAMPLE_BITS-1:0] mixed [9] = '{16'sh7fff, 16'sh8000, 16'sh0001,
                                                 16'shffff, 16'sh5555, 16'shaaaa,
                                                 16'sh7fff, 16'sh7fff, 16'sh8000};
    settle();
    write_size(2, 2);
    repeat (4) send_sample(16'sh7fff);
    repeat (4) send_sample(16'sh8000);
    settle();
    write_size(3, 3);
    foreach (mixed[i]) send_sample(mixed[i]);
  endtask

  // Resize while a frame is open, always inside an even row so that the
  // following odd row reads only line entries this row has written.
  task automatic test_resize_mid_frame();
    settle();
    write_size(4, 4);
    send_sample(random_sample());
    settle();
    write_size(1, 4);     // column 1 is now past the last column
    run_frame();
    settle();
    write_size(2, 4);
    repeat (4) send_sample(random_sample());
    settle();
    write_size(2, 1);     // row 2 is now past the last row
    run_frame();
  endtask

  // Zero and oversize register values, and the full 1024 in both registers.
  task automatic test_size_limits();
    push_gap_max = 3;
    pop_gap_max <= 3;
    settle();
    write_size(2047, 0);
    run_frame();
    settle();
    write_size(0, 2047);  // a few rows of an oversize-height frame
    repeat (6) send_sample(random_sample());
    settle();
    write_size(0, 0);     // row 6 is now past the last row
    run_frame();
    settle();
    write_size(MAX_WIDTH, HEIGHT_LIMIT);
    repeat (7) send_sample(random_sample());
    settle();
    write_size(1, 1);
    run_frame();
    push_gap_max = 9;
    pop_gap_max <= 9;
  endtask

  // Hold the receiver off while samples keep coming back to back, so the
  // queues fill and full stalls the input.
  task automatic test_output_backpressure();
    settle();
    write_size(2, 1);
    push_gap_max = 0;
    hold_requests <= hold_requests + 1;
    repeat (32) run_frame();
    push_gap_max = 9;
  endtask

  // Random frames of mostly small sizes with random idling on both sides;
  // some frames are cut short by a resize inside an even row that is not
  // the last row, so every line entry read later was written in that row.
  task automatic test_random_frames();
    int unsigned first_sample;
    int unsigned cols;
    int unsigned rows;
    int unsigned stop_row;
    int unsigned stop_col;
    first_sample = samples_sent;
    while (samples_sent - first_sample < RANDOM_SAMPLES) begin
      settle();
      cols = random_extent(10, 60);
      rows = random_extent(6, 16);
      write_size(cols, rows);
      case ($urandom_range(0, 3))
        0: begin
          push_gap_max = 9;
          pop_gap_max <= 9;
        end
        1: begin
          push_gap_max = 0;
          pop_gap_max <= 0;
        end
        2: begin
          push_gap_max = 0;
          pop_gap_max <= 9;
        end
        default: begin
          push_gap_max = 9;
          pop_gap_max <= 0;
        end
      endcase
      if (rows > 1 && $urandom_range(0, 7) == 0) begin
        stop_row = 2 * $urandom_range(0, (rows - 2) / 2);
        stop_col = $urandom_range(0, cols - 1);
        while (row_pos != stop_row || col_pos != stop_col) send_sample(random_sample());
        settle();
        write_size($urandom_range(0, 12), $urandom_range(0, 8));
      end
      run_frame();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extreme_samples();
    test_resize_mid_frame();
    test_size_limits();
    test_output_backpressure();
    test_random_frames();
    // drain and let the pipeline run empty before the verdict
    settle();
    if (mismatch_count == 0 && expected_blocks.size() == 0) begin
      $display("[binning_2x2_sum_top] OK");
    end else begin
      $display("[binning_2x2_sum_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bin2_pkg.sv
hw/rtl/bin2_ram.sv
hw/rtl/bin2_front.sv
hw/rtl/bin2_queue.sv
hw/rtl/bin2_back.sv
hw/rtl/binning_2x2_sum_top.sv
sim/testbench.sv
